/* src/gefc_pkg.sv */
// Shared types and constants for the gated edge frequency counter.
package gefc_pkg;

    localparam int SAMPLE_BITS = 10;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS = 10;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    localparam logic [9:0] TRIGGER_RESET = 10'd203;
    localparam logic [7:0] WINDOW_RESET = 8'd25;
    localparam logic [7:0] LOW_MAX_RESET = 8'd250;
    localparam logic [7:0] HIGH_DIGIT_MAX = 8'd255;

    typedef enum logic [1:0] {
        ACT_SAMPLE = 2'd0,
        ACT_TICK   = 2'd1,
        ACT_EDGE   = 2'd2,
        ACT_BUTTON = 2'd3
    } t_action;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_TRIGGER_LEVEL = 2'd0,
        CFG_WINDOW_TICKS  = 2'd1,
        CFG_LOW_DIGIT_MAX = 2'd2
    } t_cfg_index;

    typedef struct packed {
        t_action                action;
        logic [SAMPLE_BITS-1:0] sample;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic       is_rest;
    } t_out_item;

    typedef struct packed {
        logic [7:0] low_digit;
        logic [7:0] high_digit;
        logic       is_rest;
    } t_report;

endpackage

/* src/gefc_front.sv */
// Front part: configuration registers, window control and edge counting.
module gefc_front
    import gefc_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_accept,
    input  t_in_item                  i_item,
    input  logic                      i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    output logic                      o_report_push,
    output t_report                   o_report
);

    logic [SAMPLE_BITS-1:0] r_trigger;
    logic [7:0]             r_window;
    logic [7:0]             r_low_max;
    logic                   r_measuring;
    logic [7:0]             r_tick;
    logic [7:0]             r_low;
    logic [7:0]             r_high;

    logic                   n_measuring;
    logic [7:0]             n_tick;
    logic [7:0]             n_low;
    logic [7:0]             n_high;
    logic [7:0]             tick_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trigger <= TRIGGER_RESET[SAMPLE_BITS-1:0];
            r_window  <= WINDOW_RESET;
            r_low_max <= LOW_MAX_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TRIGGER_LEVEL: begin
                    r_trigger <= i_cfg_data[SAMPLE_BITS-1:0];
                end
                CFG_WINDOW_TICKS: begin
                    r_window <= i_cfg_data[7:0];
                end
                CFG_LOW_DIGIT_MAX: begin
                    r_low_max <= i_cfg_data[7:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign tick_inc = r_tick + 8'd1;

    always_comb begin
        n_measuring   = r_measuring;
        n_tick        = r_tick;
        n_low         = r_low;
        n_high        = r_high;
        o_report_push = 1'b0;
        o_report      = '{low_digit: r_low, high_digit: r_high, is_rest: 1'b0};
        if (i_accept) begin
            case (i_item.action)
                ACT_SAMPLE: begin
                    if (!r_measuring && (i_item.sample >= r_trigger)) begin
                        n_measuring = 1'b1;
                        n_tick      = 8'd0;
                    end
                end
                ACT_TICK: begin
                    if (r_measuring) begin
                        n_tick = tick_inc;
                        if (tick_inc == r_window) begin
                            o_report_push = (r_low != 8'd0) || (r_high != 8'd0);
                            n_measuring   = 1'b0;
                            n_tick        = 8'd0;
                            n_low         = 8'd0;
                            n_high        = 8'd0;
                        end
                    end
                end
                ACT_EDGE: begin
                    if (r_measuring) begin
                        if (r_low >= r_low_max) begin
                            if (r_high != HIGH_DIGIT_MAX) begin
                                n_high = r_high + 8'd1;
                                n_low  = 8'd0;
                            end
                        end else begin
                            n_low = r_low + 8'd1;
                        end
                    end
                end
                ACT_BUTTON: begin
                    o_report_push = 1'b1;
                    o_report      = '{low_digit: 8'd0, high_digit: 8'd0, is_rest: 1'b1};
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_measuring <= 1'b0;
            r_tick      <= 8'd0;
            r_low       <= 8'd0;
            r_high      <= 8'd0;
        end else begin
            r_measuring <= n_measuring;
            r_tick      <= n_tick;
            r_low       <= n_low;
            r_high      <= n_high;
        end
    end

endmodule

/* src/gefc_queue.sv */
// Short report queue between the front and back parts.
module gefc_queue
    import gefc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_report i_data,
    input  logic    i_pop,
    output t_report o_data,
    output logic    o_full,
    output logic    o_empty
);

    t_report                   r_slot [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] r_wr_ptr;
    logic [QUEUE_PTR_BITS-1:0] r_rd_ptr;
    logic [QUEUE_CNT_BITS-1:0] r_count;

    assign o_full  = (r_count == QUEUE_CNT_BITS'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10: begin
                    r_count <= r_count + 1'b1;
                end
                2'b01: begin
                    r_count <= r_count - 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("Report pushed into a full queue.");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("Report popped from an empty queue.");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QUEUE_CNT_BITS'(QUEUE_DEPTH))
        else $error("Queue count exceeds its depth.");
`endif

endmodule

/* src/gefc_back.sv */
// Back part: turns each report into two result items through an output register.
module gefc_back
    import gefc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_report   i_report,
    input  logic      i_report_empty,
    output logic      o_report_pop,
    input  logic      i_pop,
    output logic      o_empty,
    output t_out_item o_item
);

    t_report r_report;
    logic    r_valid;
    logic    r_second;
    logic    load;

    assign load = !i_report_empty && (!r_valid || (i_pop && r_second));
    assign o_report_pop = load;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_report <= i_report;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else if (load) begin
            r_valid  <= 1'b1;
            r_second <= 1'b0;
        end else if (r_valid && i_pop) begin
            if (r_second) begin
                r_valid  <= 1'b0;
                r_second <= 1'b0;
            end else begin
                r_second <= 1'b1;
            end
        end
    end

    assign o_empty         = !r_valid;
    assign o_item.out_byte = r_second ? r_report.high_digit : r_report.low_digit;
    assign o_item.last     = r_second;
    assign o_item.is_rest  = r_report.is_rest;

`ifndef SYNTHESIS
    a_second_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_second |-> r_valid)
        else $error("Second byte flagged with no report held.");

    a_drain_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_second && i_pop && i_report_empty) |=> !r_valid)
        else $error("Report not released after its last item.");
`endif

endmodule

/* src/gated_edge_frequency_counter_unit.sv */
// Top level of the gated edge frequency counter.
// One event item is taken in every clock cycle while full is low; the front
// part updates the window and the edge digits in the cycle that the item is
// accepted. Each report (a closed window with edges counted, or a button rest
// marker) enters a four-entry queue and leaves as two result items, low byte
// then high byte, one per cycle from the output register while pop is high.
// full rises only when that queue holds four reports, so the result side sets
// the sustained rate. Configuration writes are taken in every cycle.
module gated_edge_frequency_counter_unit
    import gefc_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      push,
    output logic                      full,
    input  t_in_item                  i_item,
    output logic                      empty,
    input  logic                      pop,
    output t_out_item                 o_item,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data
);

    logic    accept;
    logic    report_push;
    t_report report_in;
    t_report report_out;
    logic    report_pop;
    logic    report_full;
    logic    report_empty;

    assign full        = report_full;
    assign accept      = push && !report_full;
    assign o_cfg_ready = 1'b1;

    gefc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_item        (i_item),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_report_push (report_push),
        .o_report      (report_in)
    );

    gefc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (report_push),
        .i_data  (report_in),
        .i_pop   (report_pop),
        .o_data  (report_out),
        .o_full  (report_full),
        .o_empty (report_empty)
    );

    gefc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_report       (report_out),
        .i_report_empty (report_empty),
        .o_report_pop   (report_pop),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_item         (o_item)
    );

endmodule

/* test/tb.sv */
// Self-checking testbench for the gated edge frequency counter unit.
module tb
    import gefc_pkg::*;
();

    localparam int HALF_PERIOD = 5;
    localparam int RESET_CYCLES = 8;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT = 1000;
    localparam int HOLD_OFF_CYCLES = 80;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      push = 1'b0;
    logic                      full;
    t_in_item                  i_item = '0;
    logic                      empty;
    logic                      pop = 1'b0;
    t_out_item                 o_item;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  i_cfg_data = '0;

    logic [9:0] cfg_trigger = TRIGGER_RESET;
    logic [7:0] cfg_window = WINDOW_RESET;
    logic [7:0] cfg_low_max = LOW_MAX_RESET;
    logic       in_window = 1'b0;
    logic [7:0] ticks_seen = '0;
    logic [7:0] edges_low = '0;
    logic [7:0] edges_high = '0;

    t_out_item pending_bytes[$];
    int        fail_count = 0;
    int        idle_cycles = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    int        hold_off_left = 0;

    gated_edge_frequency_counter_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .empty       (empty),
        .pop         (pop),
        .o_item      (o_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic void count_event(input t_in_item ev);
        case (ev.action)
            ACT_SAMPLE: begin
                if (!in_window && ev.sample >= cfg_trigger) begin
                    in_window = 1'b1;
                    ticks_seen = '0;
                end
            end
            ACT_TICK: begin
                if (in_window) begin
                    ticks_seen = ticks_seen + 8'd1;
                    if (ticks_seen == cfg_window) begin
                        if (edges_low != 8'd0 || edges_high != 8'd0) begin
                            pending_bytes.push_back(t_out_item'{edges_low, 1'b0, 1'b0});
                            pending_bytes.push_back(t_out_item'{edges_high, 1'b1, 1'b0});
                        end
                        in_window = 1'b0;
                        ticks_seen = '0;
                        edges_low = '0;
                        edges_high = '0;
                    end
                end
            end
            ACT_EDGE: begin
                if (in_window) begin
                    if (edges_low >= cfg_low_max) begin
                        if (edges_high != HIGH_DIGIT_MAX) begin
                            edges_high = edges_high + 8'd1;
                            edges_low = '0;
                        end
                    end else begin
                        edges_low = edges_low + 8'd1;
                    end
                end
            end
            default: begin
                pending_bytes.push_back(t_out_item'{8'd0, 1'b0, 1'b1});
                pending_bytes.push_back(t_out_item'{8'd0, 1'b1, 1'b1});
            end
        endcase
    endfunction

    function automatic t_in_item make_event(input t_action act, input logic [9:0] level);
        t_in_item ev;
        ev.action = act;
        ev.sample = level;
        return ev;
    endfunction

    // Mostly well-formed windows: open one when idle, then edges and ticks until it closes.
    function automatic t_in_item random_event();
        t_in_item    ev;
        int unsigned roll;
        roll = $urandom_range(99);
        ev.sample = 10'($urandom_range(1023));
        ev.action = ACT_BUTTON;
        if (!in_window) begin
            if (roll < 60) begin
                ev.action = ACT_SAMPLE;
                ev.sample = 10'($urandom_range(1023, cfg_trigger));
            end else if (roll < 75) begin
                ev.action = ACT_SAMPLE;
                if (cfg_trigger != 10'd0) begin
                    ev.sample = 10'($urandom_range(cfg_trigger - 1, 0));
                end
            end else if (roll < 85) begin
                ev.action = ACT_TICK;
            end else if (roll < 95) begin
                ev.action = ACT_EDGE;
            end
        end else begin
            if (roll < 50) begin
                ev.action = ACT_EDGE;
            end else if (roll < 85) begin
                ev.action = ACT_TICK;
            end else if (roll < 93) begin
                ev.action = ACT_SAMPLE;
            end
        end
        return ev;
    endfunction

    task automatic send_event(input t_in_item ev);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push <= 1'b1;
        i_item <= ev;
        do @(posedge i_clk); while (full);
        count_event(ev);
        @(negedge i_clk);
    endtask

    task automatic wait_for_idle();
        push <= 1'b0;
        while (pending_bytes.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_register(input t_cfg_index idx, input logic [9:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_TRIGGER_LEVEL: cfg_trigger = value;
            CFG_WINDOW_TICKS:  cfg_window = value[7:0];
            default:           cfg_low_max = value[7:0];
        endcase
        @(negedge i_clk);
    endtask

    task automatic set_config(input logic [9:0] trig, input logic [7:0] win,
                              input logic [7:0] low_max);
        logic [1:0] pad;
        pad = 2'($urandom_range(3));
        wait_for_idle();
        write_register(CFG_TRIGGER_LEVEL, trig);
        write_register(CFG_WINDOW_TICKS, {pad, win});
        write_register(CFG_LOW_DIGIT_MAX, {~pad, low_max});
        i_cfg_valid <= 1'b0;
    endtask

    task automatic finish_window();
        while (in_window) send_event(make_event(ACT_TICK, 10'($urandom_range(1023))));
    endtask

    task automatic test_reset_config();
        send_event(make_event(ACT_SAMPLE, 10'd0));
        send_event(make_event(ACT_SAMPLE, 10'd202));
        send_event(make_event(ACT_TICK, 10'h3FF));
        send_event(make_event(ACT_EDGE, 10'h3FF));
        send_event(make_event(ACT_SAMPLE, 10'd203));
        send_event(make_event(ACT_SAMPLE, 10'h3FF));
        send_event(make_event(ACT_EDGE, 10'd0));
        send_event(make_event(ACT_EDGE, 10'h155));
        send_event(make_event(ACT_BUTTON, 10'h2AA));
        send_event(make_event(ACT_TICK, 10'd0));
    endtask

    task automatic test_threshold_extremes();
        finish_window();
        set_config(10'h3FF, 8'd1, 8'd255);
        send_event(make_event(ACT_SAMPLE, 10'h3FE));
        send_event(make_event(ACT_SAMPLE, 10'h3FF));
        send_event(make_event(ACT_TICK, 10'd0));
        send_event(make_event(ACT_EDGE, 10'd0));
        send_event(make_event(ACT_SAMPLE, 10'h3FF));
        send_event(make_event(ACT_EDGE, 10'd0));
        send_event(make_event(ACT_EDGE, 10'd0));
        send_event(make_event(ACT_TICK, 10'd0));
    endtask

    // A zero low maximum carries on every edge, so the high digit reaches full scale and holds.
    task automatic test_digit_saturation();
        finish_window();
        set_config(10'd0, 8'd1, 8'd0);
        send_idle_pct = 27;
        recv_stall_pct = 27;
        send_event(make_event(ACT_SAMPLE, 10'd0));
        repeat (128) send_event(make_event(ACT_EDGE, 10'($urandom_range(1023))));
        send_event(make_event(ACT_BUTTON, 10'd0));
        repeat (128) send_event(make_event(ACT_EDGE, 10'($urandom_range(1023))));
        send_event(make_event(ACT_TICK, 10'($urandom_range(1023))));
        send_event(make_event(ACT_EDGE, 10'd0));
        send_event(make_event(ACT_TICK, 10'd0));
    endtask

    task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
                                       input int count, input bit reconfigure);
        if (reconfigure) begin
            set_config(10'($urandom_range(1023)), 8'($urandom_range(12, 1)),
                       8'($urandom_range(6, 1)));
        end
        send_idle_pct = sender_pct;
        recv_stall_pct = receiver_pct;
        repeat (count) send_event(random_event());
    endtask

    task automatic test_backpressure();
        set_config(10'($urandom_range(1023)), 8'd255, 8'd2);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_left = HOLD_OFF_CYCLES;
        repeat (16) send_event(make_event(ACT_BUTTON, 10'($urandom_range(1023))));
        repeat (30) send_event(random_event());
        wait_for_idle();
        repeat (20) send_event(random_event());
    endtask

    always @(negedge i_clk) begin
        if (hold_off_left > 0) begin
            pop <= 1'b0;
            hold_off_left--;
        end else begin
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && pop && !empty) begin
            if (pending_bytes.size() == 0) begin
                $error("out_byte: expected no item, got %0d", o_item.out_byte);
                fail_count++;
            end else begin
                want = pending_bytes.pop_front();
                if (o_item.out_byte !== want.out_byte) begin
                    $error("out_byte: expected %0d, got %0d", want.out_byte, o_item.out_byte);
                    fail_count++;
                end
                if (o_item.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, o_item.last);
                    fail_count++;
                end
                if (o_item.is_rest !== want.is_rest) begin
                    $error("is_rest: expected %0d, got %0d", want.is_rest, o_item.is_rest);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_config();
        test_random_traffic(0, 0, 30, 1'b0);
        test_threshold_extremes();
        test_digit_saturation();
        test_random_traffic(56, 0, 30, 1'b1);
        test_random_traffic(0, 56, 30, 1'b1);
        test_random_traffic(27, 27, 30, 1'b1);
        test_backpressure();
        set_config(10'h3FF, 8'd1, 8'd1);
        test_random_traffic(0, 0, 30, 1'b0);
        wait_for_idle();
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

/* gated_edge_frequency_counter_unit.f */
src/gefc_pkg.sv
src/gefc_front.sv
src/gefc_queue.sv
src/gefc_back.sv
src/gated_edge_frequency_counter_unit.sv
test/tb.sv
